>>> rtl/core/voxel_surface_extract_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel surface extraction unit
// Concurrent property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef VOXEL_SURFACE_EXTRACT_UNIT_MACROS_SVH
`define VOXEL_SURFACE_EXTRACT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("vse: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("vse: next-cycle check failed");

`endif

>>> rtl/core/vse_pkg.sv
// ----------------------------------------------------------------------------
// vse_pkg
// Shared sizes, register indexes, action codes and memory request type.
// ----------------------------------------------------------------------------
`default_nettype none

package vse_pkg;

	// volume limits of the column store
	localparam int MAX_X = 64;
	localparam int MAX_Y = 64;
	localparam int MAX_Z = 64;

	// field widths
	localparam int COORD_W = 6;
	localparam int COL_W   = 64;
	localparam int SIZE_W  = 7;
	localparam int CFG_IDX_W = 2;

	// column memory geometry
	localparam int DEPTH  = MAX_X * MAX_Y;
	localparam int ADDR_W = $clog2(DEPTH);

	// reset value of the size registers
	localparam int SIZE_RESET = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// item action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// request to the column memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
	} ram_req_t;

	// linear column address of (x, y)
	function automatic logic [ADDR_W-1:0] col_addr(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		col_addr = ADDR_W'(ADDR_W'(x) * ADDR_W'(MAX_Y) + ADDR_W'(y));
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/vse_column_ram.sv
// ----------------------------------------------------------------------------
// vse_column_ram
// Single-port column memory, one column per (x, y), registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vse_column_ram
	import vse_pkg::*;
(
	input  wire logic             clk,
	input  wire ram_req_t         req,
	input  wire logic [COL_W-1:0] wdata,
	output logic      [COL_W-1:0] rdata
);

	logic [COL_W-1:0] mem [DEPTH];
	logic [COL_W-1:0] rdata_q;

	// write, or read into the registered read data
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= wdata;
		end else begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/voxel_surface_extract_unit.sv
// ----------------------------------------------------------------------------
// voxel_surface_extract_unit
// Column store of a bit volume with 6-neighbor surface queries.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  input     | start, busy                | action, col_x, col_y, occupancy
//  result    | done (one-cycle strobe)    | res_x, res_y, surface_bits
//  config    | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
//  A write item stores its column at the accept edge and leaves busy low.
//  A query item keeps busy high while it reads the single-port column memory
//  (own column, x-1, x+1, y-1, y+1); done rises at the edge where busy falls,
//  and a new item may be accepted at the edge that ends the done cycle.
//  Reset clears control state and sets all sizes to 64; the column memory
//  is not cleared, and the user must see that every column in range is
//  written before it is queried; the block does not enforce this.
//  The result side has no back-pressure; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_surface_extract_unit
	import vse_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input items
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 action,
	input  wire logic [COORD_W-1:0]   col_x,
	input  wire logic [COORD_W-1:0]   col_y,
	input  wire logic [COL_W-1:0]     occupancy,
	// result items
	output logic                      done,
	output logic      [COORD_W-1:0]   res_x,
	output logic      [COORD_W-1:0]   res_y,
	output logic      [COL_W-1:0]     surface_bits,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data
);

	// read step codes: which column a step reads
	localparam logic [2:0] STEP_CTR = 3'd0;
	localparam logic [2:0] STEP_XM  = 3'd1;
	localparam logic [2:0] STEP_XP  = 3'd2;
	localparam logic [2:0] STEP_YM  = 3'd3;
	localparam logic [2:0] STEP_YP  = 3'd4;
	localparam logic [2:0] STEP_LAST = STEP_YP;

	localparam logic [SIZE_W-1:0] ONE_S   = SIZE_W'(1);
	localparam logic [SIZE_W-1:0] MINUS_S = '1;

	// neighbor coordinate of a step; x-1 below zero wraps to a value out of range
	function automatic logic [2*SIZE_W-1:0] nb_xy(input logic [2:0] step,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		logic [SIZE_W-1:0] bx;
		logic [SIZE_W-1:0] by;
		bx = SIZE_W'(x);
		by = SIZE_W'(y);
		case (step)
			STEP_XM: nb_xy = {SIZE_W'(bx + MINUS_S), by};
			STEP_XP: nb_xy = {SIZE_W'(bx + ONE_S), by};
			STEP_YM: nb_xy = {bx, SIZE_W'(by + MINUS_S)};
			STEP_YP: nb_xy = {bx, SIZE_W'(by + ONE_S)};
			default: nb_xy = {bx, by};
		endcase
	endfunction

	// control state
	logic              busy_q;
	logic [2:0]        cnt_q;
	logic              done_q;
	logic [SIZE_W-1:0] size_x_q;
	logic [SIZE_W-1:0] size_y_q;
	logic [SIZE_W-1:0] size_z_q;

	// payload state
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COL_W-1:0]   occ_q;
	logic [COL_W-1:0]   acc_q;
	logic [COORD_W-1:0] res_x_q;
	logic [COORD_W-1:0] res_y_q;
	logic [COL_W-1:0]   surf_q;

	logic              accept;
	logic              in_store;
	logic [SIZE_W-1:0] ext_x;
	logic [SIZE_W-1:0] ext_y;
	logic [SIZE_W-1:0] ext_z;
	logic [COL_W-1:0]  zmask;
	logic [2*SIZE_W-1:0] cur_xy;
	logic [2*SIZE_W-1:0] nxt_xy;
	logic              cur_ok;
	logic [COL_W-1:0]  rdata;
	logic [COL_W-1:0]  masked;
	ram_req_t          ram_req;

	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;
	assign in_store  = (int'(col_x) < MAX_X) && (int'(col_y) < MAX_Y);

	// limit the sizes to the store
	assign ext_x = (size_x_q > SIZE_W'(MAX_X)) ? SIZE_W'(MAX_X) : size_x_q;
	assign ext_y = (size_y_q > SIZE_W'(MAX_Y)) ? SIZE_W'(MAX_Y) : size_y_q;
	assign ext_z = (size_z_q > SIZE_W'(MAX_Z)) ? SIZE_W'(MAX_Z) : size_z_q;

	// keep only bits below the z extent
	always_comb begin
		for (int i = 0; i < COL_W; i++) begin
			zmask[i] = SIZE_W'(i) < ext_z;
		end
	end

	// column under processing this cycle and column to read next
	assign cur_xy = nb_xy(cnt_q, x_q, y_q);
	assign nxt_xy = nb_xy(3'(cnt_q + 3'd1), x_q, y_q);
	assign cur_ok = (cur_xy[2*SIZE_W-1:SIZE_W] < ext_x) && (cur_xy[SIZE_W-1:0] < ext_y);

	// write when idle, else read the next step's column
	always_comb begin
		ram_req.we = accept && (action == ACT_WRITE) && in_store;
		if (busy_q) begin
			ram_req.addr = col_addr(nxt_xy[SIZE_W+COORD_W-1:SIZE_W], nxt_xy[COORD_W-1:0]);
		end else begin
			ram_req.addr = col_addr(col_x, col_y);
		end
	end

	vse_column_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.wdata (occupancy),
		.rdata (rdata)
	);

	// columns outside the extents count as empty
	assign masked = cur_ok ? (rdata & zmask) : '0;

	// sequence the five reads of a query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= STEP_CTR;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (accept && (action == ACT_QUERY)) begin
					busy_q <= 1'b1;
					cnt_q  <= STEP_CTR;
				end
			end else if (cnt_q == STEP_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= 3'(cnt_q + 3'd1);
			end
		end
	end

	// hold sizes; ignore indexes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(SIZE_RESET);
			size_y_q <= SIZE_W'(SIZE_RESET);
			size_z_q <= SIZE_W'(SIZE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the query and fold in each column as it arrives
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= col_x;
			y_q <= col_y;
		end
		if (busy_q) begin
			if (cnt_q == STEP_CTR) begin
				occ_q <= masked;
				acc_q <= masked & (masked >> 1) & (masked << 1);
			end else if (cnt_q == STEP_LAST) begin
				surf_q  <= occ_q & ~(acc_q & masked);
				res_x_q <= x_q;
				res_y_q <= y_q;
			end else begin
				acc_q <= acc_q & masked;
			end
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign res_x        = res_x_q;
	assign res_y        = res_y_q;
	assign surface_bits = surf_q;

endmodule

`default_nettype wire

>>> rtl/core/vse_checker.sv
// ----------------------------------------------------------------------------
// vse_checker
// Port-level timing checks of the voxel surface extraction unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_surface_extract_unit_macros.svh"

module vse_checker
	import vse_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic action,
	input wire logic done
);

	// a result appears only once the query has released the unit
	`VSE_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)

	// a result closes a query that was in progress
	`VSE_ASSERT_NOW(a_done_after_busy, clk, arst_n, done, $past(busy))

	// an accepted query occupies the unit
	`VSE_ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && (action == ACT_QUERY), busy)

	// an accepted write finishes at once and gives no result
	`VSE_ASSERT_NEXT(a_write_quiet, clk, arst_n, start && !busy && (action == ACT_WRITE),
		!busy && !done)

	// one strobe per query
	`VSE_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

endmodule

bind voxel_surface_extract_unit vse_checker u_vse_checker (.*);

`default_nettype wire
